FILE: hw/rtl/brf_pkg.sv
package brf_pkg;

  // Fixed field widths of the stream items and the capacity register.
  localparam int COUNT_W      = 11;
  localparam int CAP_W        = 11;
  localparam int BYTE_W       = 8;
  localparam int USED_W       = 11;
  localparam int TDATA_IN_W   = 24;
  localparam int TUSER_IN_W   = 2;
  localparam int TDATA_OUT_W  = 24;
  localparam int TUSER_OUT_W  = 3;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEF    = 1024;
  localparam int MAX_READ_DEF = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // Operation codes carried in the input tuser.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [2:0] {
    KIND_ACCEPT  = 3'd0,
    KIND_NOSPACE = 3'd1,
    KIND_TOOBIG  = 3'd2,
    KIND_DATA    = 3'd3,
    KIND_EMPTY   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  // One result handed from the controller to the output stage.
  typedef struct packed {
    logic              load;
    kind_e             kind;
    logic              last;
    logic              bell_reader;
    logic              bell_writer;
    logic [USED_W-1:0] used_after;
    logic              from_mem;
  } res_t;

endpackage

FILE: hw/rtl/brf_mem.sv
module brf_mem #(
  parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  logic [brf_pkg::BYTE_W-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  output logic [brf_pkg::BYTE_W-1:0] rd_data_o
);

  logic [brf_pkg::BYTE_W-1:0] store_q [DEPTH];
  logic [brf_pkg::BYTE_W-1:0] rd_data_q;

  // The read register only changes on a read, so a returned byte holds
  // until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      store_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= store_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/brf_ctrl.sv
module brf_ctrl #(
  parameter int DEPTH    = brf_pkg::DEPTH_DEF,
  parameter int MAX_READ = brf_pkg::MAX_READ_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [brf_pkg::COUNT_W-1:0] count_i,
  input  logic                        first_i,
  input  logic [brf_pkg::BYTE_W-1:0]  wbyte_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [brf_pkg::CAP_W-1:0]   cfg_data_i,
  input  logic                        can_load_i,
  output logic                        mem_wr_en_o,
  output logic [$clog2(DEPTH)-1:0]    mem_wr_addr_o,
  output logic [brf_pkg::BYTE_W-1:0]  mem_wr_data_o,
  output logic                        mem_rd_en_o,
  output logic [$clog2(DEPTH)-1:0]    mem_rd_addr_o,
  output brf_pkg::res_t               res_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int NW = (CW > brf_pkg::COUNT_W) ? CW : brf_pkg::COUNT_W;
  localparam int RW = $clog2(MAX_READ + 1);
  localparam logic [NW-1:0] DEPTH_N    = NW'(DEPTH);
  localparam logic [NW-1:0] MAX_READ_N = NW'(MAX_READ);
  localparam logic [NW-1:0] ONE_N      = NW'(1);

  brf_pkg::state_e             state_q, state_d;
  logic [brf_pkg::CAP_W-1:0]   cap_q, cap_d;
  logic [AW-1:0]               wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]               used_q, used_d;
  logic                        wws_q, wws_d, rwd_q, rwd_d;
  logic [brf_pkg::COUNT_W-1:0] left_q, left_d;
  logic                        drop_q, drop_d;
  logic [RW-1:0]               rd_left_q, rd_left_d;
  logic                        pend_q, pend_d;
  logic                        pend_last_q, pend_last_d;
  logic                        pend_bw_q, pend_bw_d;
  logic [NW-1:0]               pend_used_q, pend_used_d;

  logic          in_accept, cfg_accept, issue;
  logic [NW-1:0] cap_n, cap_eff, used_n, wp_n, rp_n, count_n, free_n;
  logic [NW-1:0] wp_inc, rp_inc, wp_next, rp_next, left_dec;
  logic [NW-1:0] want, chunk, chunk_cap, n_rd, used_after;
  logic          store_ok;

  assign cfg_ready_o = (state_q == brf_pkg::ST_IDLE) && !pend_q;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == brf_pkg::ST_IDLE) && !pend_q && can_load_i && !cfg_valid_i;
  assign in_accept   = in_valid_i && in_ready_o;

  always_comb begin
    cap_n   = NW'(cap_q);
    cap_eff = (cap_n == '0) ? ONE_N : ((cap_n > DEPTH_N) ? DEPTH_N : cap_n);
    used_n  = NW'(used_q);
    wp_n    = NW'(wp_q);
    rp_n    = NW'(rp_q);
    count_n = NW'(count_i);
    free_n  = cap_eff - used_n;
    wp_inc  = wp_n + ONE_N;
    rp_inc  = rp_n + ONE_N;
    wp_next = (wp_inc >= cap_eff) ? '0 : wp_inc;
    rp_next = (rp_inc >= cap_eff) ? '0 : rp_inc;
    left_dec = NW'(left_q) - ONE_N;
    store_ok = used_n < cap_eff;
    want     = (count_n > MAX_READ_N) ? MAX_READ_N : count_n;
    chunk_cap = (cap_eff > rp_n) ? (cap_eff - rp_n) : ONE_N;
    chunk    = (rp_n < wp_n) ? used_n : chunk_cap;
    chunk    = (chunk > used_n) ? used_n : chunk;
    n_rd     = (want < chunk) ? want : chunk;
    issue    = (state_q == brf_pkg::ST_READ) && (rd_left_q != '0) && (!pend_q || can_load_i);
  end

  always_comb begin
    state_d     = state_q;
    cap_d       = cap_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    used_d      = used_q;
    wws_d       = wws_q;
    rwd_d       = rwd_q;
    left_d      = left_q;
    drop_d      = drop_q;
    rd_left_d   = rd_left_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    pend_bw_d   = pend_bw_q;
    pend_used_d = pend_used_q;
    used_after  = used_n;

    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = wp_q;
    mem_wr_data_o = wbyte_i;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = rp_q;

    res_o             = '0;
    res_o.kind        = brf_pkg::KIND_ACCEPT;
    res_o.last        = 1'b1;

    // A returned byte leaves for the output stage as soon as it has room.
    if (pend_q && can_load_i) begin
      res_o.load        = 1'b1;
      res_o.kind        = brf_pkg::KIND_DATA;
      res_o.last        = pend_last_q;
      res_o.bell_writer = pend_bw_q;
      res_o.used_after  = pend_used_q[brf_pkg::USED_W-1:0];
      res_o.from_mem    = 1'b1;
      pend_d            = 1'b0;
    end

    if (cfg_accept) begin
      cap_d     = cfg_data_i;
      wp_d      = '0;
      rp_d      = '0;
      used_d    = '0;
      wws_d     = 1'b0;
      rwd_d     = 1'b0;
      left_d    = '0;
      drop_d    = 1'b0;
      rd_left_d = '0;
      pend_d    = 1'b0;
      state_d   = brf_pkg::ST_IDLE;
    end else begin
      case (state_q)
        brf_pkg::ST_IDLE: begin
          if (in_accept && op_i == brf_pkg::OP_WRITE) begin
            if (first_i) begin
              left_d = '0;
              drop_d = 1'b0;
              if (count_n > cap_eff) begin
                left_d     = count_i - brf_pkg::COUNT_W'(1);
                drop_d     = (count_i != brf_pkg::COUNT_W'(1));
                res_o.load = 1'b1;
                res_o.kind = brf_pkg::KIND_TOOBIG;
              end else if (count_n > free_n) begin
                wws_d      = 1'b1;
                left_d     = count_i - brf_pkg::COUNT_W'(1);
                drop_d     = (count_i != brf_pkg::COUNT_W'(1));
                res_o.load = 1'b1;
                res_o.kind = brf_pkg::KIND_NOSPACE;
              end else begin
                wws_d      = 1'b0;
                res_o.load = 1'b1;
                if (count_i == '0) begin
                  res_o.bell_reader = rwd_q;
                end else begin
                  left_d            = count_i - brf_pkg::COUNT_W'(1);
                  res_o.bell_reader = (count_i == brf_pkg::COUNT_W'(1)) && rwd_q;
                  if (store_ok) begin
                    mem_wr_en_o = 1'b1;
                    wp_d        = AW'(wp_next);
                    used_d      = CW'(used_n + ONE_N);
                    used_after  = used_n + ONE_N;
                  end
                end
              end
            end else if (left_q == '0) begin
              // Stray byte outside any packet.
              drop_d = 1'b0;
            end else begin
              left_d = left_dec[brf_pkg::COUNT_W-1:0];
              if (drop_q) begin
                if (left_dec == '0) begin
                  drop_d = 1'b0;
                end
              end else begin
                res_o.load        = 1'b1;
                res_o.bell_reader = (left_dec == '0) && rwd_q;
                if (store_ok) begin
                  mem_wr_en_o = 1'b1;
                  wp_d        = AW'(wp_next);
                  used_d      = CW'(used_n + ONE_N);
                  used_after  = used_n + ONE_N;
                end
              end
            end
            res_o.used_after = used_after[brf_pkg::USED_W-1:0];
          end else if (in_accept) begin
            res_o.used_after = used_n[brf_pkg::USED_W-1:0];
            if (want == '0) begin
              res_o.load = 1'b1;
              res_o.kind = brf_pkg::KIND_EMPTY;
            end else if (used_n == '0) begin
              rwd_d      = 1'b1;
              res_o.load = 1'b1;
              res_o.kind = brf_pkg::KIND_EMPTY;
            end else begin
              rwd_d     = 1'b0;
              rd_left_d = RW'(n_rd);
              state_d   = brf_pkg::ST_READ;
            end
          end
        end
        brf_pkg::ST_READ: begin
          if (issue) begin
            mem_rd_en_o = 1'b1;
            rp_d        = AW'(rp_next);
            used_d      = CW'(used_n - ONE_N);
            pend_d      = 1'b1;
            pend_last_d = (rd_left_q == RW'(1));
            pend_bw_d   = (rd_left_q == RW'(1)) && wws_q;
            pend_used_d = used_n - ONE_N;
            rd_left_d   = rd_left_q - RW'(1);
            if (rd_left_q == RW'(1)) begin
              state_d = brf_pkg::ST_IDLE;
            end
          end
        end
        default: begin
          state_d = brf_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= brf_pkg::ST_IDLE;
      cap_q     <= brf_pkg::CAP_RESET;
      wp_q      <= '0;
      rp_q      <= '0;
      used_q    <= '0;
      wws_q     <= 1'b0;
      rwd_q     <= 1'b0;
      left_q    <= '0;
      drop_q    <= 1'b0;
      rd_left_q <= '0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cap_q     <= cap_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      used_q    <= used_d;
      wws_q     <= wws_d;
      rwd_q     <= rwd_d;
      left_q    <= left_d;
      drop_q    <= drop_d;
      rd_left_q <= rd_left_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_last_q <= pend_last_d;
    pend_bw_q   <= pend_bw_d;
    pend_used_q <= pend_used_d;
  end

endmodule

FILE: hw/rtl/brf_out.sv
module brf_out (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  brf_pkg::res_t                   res_i,
  input  logic [brf_pkg::BYTE_W-1:0]      rd_data_i,
  output logic                            can_load_o,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [brf_pkg::TDATA_OUT_W-1:0] tdata_o,
  output logic [brf_pkg::TUSER_OUT_W-1:0] tuser_o,
  output logic                            tlast_o
);

  localparam int PAD_W = brf_pkg::TDATA_OUT_W - brf_pkg::BYTE_W - 2 - brf_pkg::USED_W;

  logic                               valid_q;
  logic [brf_pkg::TDATA_OUT_W-1:0]    tdata_q, tdata_d;
  brf_pkg::kind_e                     kind_q;
  logic                               last_q;
  logic [brf_pkg::BYTE_W-1:0]         byte_d;

  assign can_load_o = !valid_q || ready_i;

  always_comb begin
    byte_d  = res_i.from_mem ? rd_data_i : '0;
    tdata_d = {{PAD_W{1'b0}}, res_i.used_after, res_i.bell_writer, res_i.bell_reader, byte_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_i.load) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.load) begin
      tdata_q <= tdata_d;
      kind_q  <= res_i.kind;
      last_q  <= res_i.last;
    end
  end

  assign valid_o = valid_q;
  assign tdata_o = tdata_q;
  assign tuser_o = kind_q;
  assign tlast_o = last_q;

endmodule

FILE: hw/rtl/byte_ring_all_or_nothing_fifo.sv
// Byte ring buffer with all-or-nothing packet admission. Write packets arrive one byte per
// beat; the first byte carries the packet length, and the whole packet is admitted, refused
// for lack of free space, or refused as larger than the ring, on that byte alone. Each stored
// byte gives one result beat, as does the first byte of a refused or zero-length packet;
// other dropped bytes and stray bytes give none. A read request returns up to the requested
// number of bytes (at most MAX_READ) from the contiguous pending bytes before the wrap point,
// one result beat per byte, or a single empty-status beat. Rate: write bytes are taken one
// per cycle while the output has room; a read returns one byte per cycle through the single
// read port of the byte store while the output is not stalled, each byte passing through the
// store's read register. The next beat is accepted only once the last returned byte has left
// the store's read register. Writing the capacity register empties the ring; the store itself
// is never cleared, so there is no clearing pass after reset. The capacity register resets to
// 1024; zero behaves as one, and values above DEPTH behave as DEPTH.
module byte_ring_all_or_nothing_fifo #(
  parameter int DEPTH    = brf_pkg::DEPTH_DEF,
  parameter int MAX_READ = brf_pkg::MAX_READ_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [10:0] byte_count, [18:11] write_byte, [23:19] zero
  input  logic [brf_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
  // [0] operation, [1] first_byte
  input  logic [brf_pkg::TUSER_IN_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] read_byte, [8] bell_reader, [9] bell_writer, [20:10] used_after, [23:21] zero
  output logic [brf_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  // [2:0] kind
  output logic [brf_pkg::TUSER_OUT_W-1:0] m_axis_tuser,
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [brf_pkg::CAP_W-1:0]       cfg_data_i
);

  localparam int AW = $clog2(DEPTH);

  logic                       can_load;
  logic                       mem_wr_en, mem_rd_en;
  logic [AW-1:0]              mem_wr_addr, mem_rd_addr;
  logic [brf_pkg::BYTE_W-1:0] mem_wr_data, mem_rd_data;
  brf_pkg::res_t              res;

  // The controller owns the pointers, the pending count and the packet state,
  // and sequences the reads of the byte store one byte per cycle while the output stage has room.
  brf_ctrl #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .op_i          (s_axis_tuser[0]),
    .count_i       (s_axis_tdata[10:0]),
    .first_i       (s_axis_tuser[1]),
    .wbyte_i       (s_axis_tdata[18:11]),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .can_load_i    (can_load),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .res_o         (res)
  );

  // The byte store: one write port and one registered read port.
  brf_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  // The output register decouples the result stream from the controller, so a new
  // beat can be taken while the previous result is being taken downstream, but not while it still waits.
  brf_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .rd_data_i  (mem_rd_data),
    .can_load_o (can_load),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .tdata_o    (m_axis_tdata),
    .tuser_o    (m_axis_tuser),
    .tlast_o    (m_axis_tlast)
  );

endmodule

FILE: hw/rtl/brf_checker.sv
module brf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [brf_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  input logic [brf_pkg::TUSER_OUT_W-1:0] m_axis_tuser,
  input logic                            m_axis_tlast
);

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // Only read data carries a byte.
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != brf_pkg::KIND_DATA |-> m_axis_tdata[7:0] == '0)
    else $error("read byte set on a non-data result");

  // The writer bell rings only on the last byte of a read.
  a_bell_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tlast && m_axis_tuser == brf_pkg::KIND_DATA)
    else $error("writer bell outside the last read byte");

  // The reader bell rings only on an accepted write.
  a_bell_reader: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tuser == brf_pkg::KIND_ACCEPT)
    else $error("reader bell on a result other than an accepted write");

endmodule

bind byte_ring_all_or_nothing_fifo brf_checker u_brf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
